### hdl/rpp_pkg.sv
// Shared types, constants and register codes for the RGB pixel point-operation block.
// Used by every module in the hdl folder; depends on nothing else.
package rpp_pkg;

  // Field and register widths.
  localparam int CH_W       = 8;
  localparam int SIDE_CFG_W = 13;
  localparam int GAIN_W     = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int MAX_SIDE_DEF    = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Grayscale: floor((30r + 59g + 11b) / 100), the division done as a multiply
  // by a reciprocal that is exact for every sum below 43699.
  localparam int GRAY_SUM_W = 15;
  localparam int GRAY_WR    = 30;
  localparam int GRAY_WG    = 59;
  localparam int GRAY_WB    = 11;
  localparam int GRAY_RECIP = 5243;
  localparam int GRAY_SHIFT = 19;

  // Contrast: floor(((2c - 255) * gain + 65280) / 512), saturated to 0..255.
  localparam int CON_DIFF_W = 10;
  localparam int CON_PROD_W = CON_DIFF_W + GAIN_W;
  localparam int CON_SUM_W  = CON_PROD_W + 1;
  localparam int CON_BIAS   = 65280;
  localparam int CON_SHIFT  = 9;
  localparam int CH_MAX     = 255;

  // Register reset values.
  localparam logic [MODE_W-1:0]      MODE_RST  = '0;
  localparam logic [SIDE_CFG_W-1:0]  SIDE_RST  = SIDE_CFG_W'(1);
  localparam logic [SIDE_CFG_W-1:0]  CROP_RST  = '0;
  localparam logic signed [GAIN_W-1:0] GAIN_RST = GAIN_W'(256);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_CROP_COL_A   = 3'd3,
    REG_CROP_COL_B   = 3'd4,
    REG_CROP_ROW_A   = 3'd5,
    REG_CROP_ROW_B   = 3'd6,
    REG_CONTRAST     = 3'd7
  } reg_idx_e;

  // Operation modes as held in the mode register.
  typedef enum logic [MODE_W-1:0] {
    MODE_SWAP     = 3'd0,
    MODE_GRAY     = 3'd1,
    MODE_BLACKOUT = 3'd2,
    MODE_CONTRAST = 3'd3,
    MODE_CROP     = 3'd4
  } mode_e;

  // Work that the back end applies to one queued pixel.
  typedef enum logic [1:0] {
    OP_PASS     = 2'd0,
    OP_SWAP     = 2'd1,
    OP_GRAY     = 2'd2,
    OP_CONTRAST = 2'd3
  } op_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [SIDE_CFG_W-1:0]     frame_width;
    logic [SIDE_CFG_W-1:0]     frame_height;
    logic [SIDE_CFG_W-1:0]     crop_col_a;
    logic [SIDE_CFG_W-1:0]     crop_col_b;
    logic [SIDE_CFG_W-1:0]     crop_row_a;
    logic [SIDE_CFG_W-1:0]     crop_row_b;
    logic signed [GAIN_W-1:0]  contrast_gain;
  } cfg_t;

  // One classified pixel on its way from the front end to the back end.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    op_e             op;
    logic            blank;
    logic            frame_end;
  } rec_t;

endpackage

### hdl/rpp_cfg_regs.sv
// Configuration register file of the RGB pixel point-operation block.
// Depends on rpp_pkg for the register indexes and the cfg_t record.
module rpp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rpp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rpp_pkg::cfg_t                  cfg_o
);
  import rpp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are taken in every cycle.
  assign cfg_ready_o = 1'b1;

  // Decode the register index of a write request.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_MODE:         cfg_d.mode          = cfg_data_i[MODE_W-1:0];
        REG_FRAME_WIDTH:  cfg_d.frame_width   = cfg_data_i[SIDE_CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height  = cfg_data_i[SIDE_CFG_W-1:0];
        REG_CROP_COL_A:   cfg_d.crop_col_a    = cfg_data_i[SIDE_CFG_W-1:0];
        REG_CROP_COL_B:   cfg_d.crop_col_b    = cfg_data_i[SIDE_CFG_W-1:0];
        REG_CROP_ROW_A:   cfg_d.crop_row_a    = cfg_data_i[SIDE_CFG_W-1:0];
        REG_CROP_ROW_B:   cfg_d.crop_row_b    = cfg_data_i[SIDE_CFG_W-1:0];
        REG_CONTRAST:     cfg_d.contrast_gain = $signed(cfg_data_i[GAIN_W-1:0]);
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // Register storage with reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_RST;
      cfg_q.frame_width   <= SIDE_RST;
      cfg_q.frame_height  <= SIDE_RST;
      cfg_q.crop_col_a    <= CROP_RST;
      cfg_q.crop_col_b    <= CROP_RST;
      cfg_q.crop_row_a    <= CROP_RST;
      cfg_q.crop_row_b    <= CROP_RST;
      cfg_q.contrast_gain <= GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/rpp_front.sv
// Front end: raster position counters and per-pixel classification.
// Depends on rpp_pkg; feeds classified records to rpp_queue.
module rpp_front #(
  parameter int MAX_SIDE = rpp_pkg::MAX_SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rpp_pkg::cfg_t            cfg_i,
  input  logic                     accept_i,
  input  logic [rpp_pkg::CH_W-1:0] red_i,
  input  logic [rpp_pkg::CH_W-1:0] green_i,
  input  logic [rpp_pkg::CH_W-1:0] blue_i,
  output logic                     wr_en_o,
  output rpp_pkg::rec_t            rec_o
);
  import rpp_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = CNT_W + 1;
  localparam int CMP_W  = ((SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W) + 1;

  logic [CNT_W-1:0] row_q, row_d, col_q, col_d;
  logic [CMP_W-1:0] w, h, row, col, row1, col1;
  logic [CMP_W-1:0] clo, chi, rlo, rhi, ca, cb, ra, rb;
  logic             last_col, last_row, in_win, keep;

  // A zero side acts as one, an oversized side as the maximum.
  function automatic logic [CMP_W-1:0] eff_side(input logic [SIDE_CFG_W-1:0] v);
    logic [CMP_W-1:0] x;
    x = CMP_W'(v);
    if (x == '0) begin
      return CMP_W'(1);
    end else if (x > CMP_W'(MAX_SIDE)) begin
      return CMP_W'(MAX_SIDE);
    end
    return x;
  endfunction

  // Position and frame geometry.
  always_comb begin
    w        = eff_side(cfg_i.frame_width);
    h        = eff_side(cfg_i.frame_height);
    row      = CMP_W'(row_q);
    col      = CMP_W'(col_q);
    row1     = row + CMP_W'(1);
    col1     = col + CMP_W'(1);
    last_col = (col1 >= w);
    last_row = (row1 >= h);
  end

  // Crop window: order the corners and clip the upper bounds to the frame.
  always_comb begin
    ca  = CMP_W'(cfg_i.crop_col_a);
    cb  = CMP_W'(cfg_i.crop_col_b);
    ra  = CMP_W'(cfg_i.crop_row_a);
    rb  = CMP_W'(cfg_i.crop_row_b);
    clo = (ca < cb) ? ca : cb;
    chi = (ca < cb) ? cb : ca;
    rlo = (ra < rb) ? ra : rb;
    rhi = (ra < rb) ? rb : ra;
    if (chi > w) begin
      chi = w;
    end
    if (rhi > h) begin
      rhi = h;
    end
    in_win = (col >= clo) && (col < chi) && (row >= rlo) && (row < rhi);
  end

  // Classify the pixel for the back end.
  always_comb begin
    rec_o.red       = red_i;
    rec_o.green     = green_i;
    rec_o.blue      = blue_i;
    rec_o.op        = OP_PASS;
    rec_o.blank     = 1'b0;
    rec_o.frame_end = last_col && last_row;
    keep            = 1'b1;
    unique case (mode_e'(cfg_i.mode))
      MODE_SWAP:     rec_o.op = OP_SWAP;
      MODE_GRAY:     rec_o.op = OP_GRAY;
      MODE_BLACKOUT: rec_o.blank = (row < (h >> 1)) && (col >= (w >> 1));
      MODE_CONTRAST: rec_o.op = OP_CONTRAST;
      MODE_CROP: begin
        keep            = in_win;
        rec_o.frame_end = (col1 == chi) && (row1 == rhi);
      end
      default:       rec_o.op = OP_PASS;
    endcase
  end

  assign wr_en_o = accept_i && keep;

  // Counters advance on every accepted pixel and wrap at the frame end.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row1[CNT_W-1:0];
      end else begin
        col_d = col1[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

### hdl/rpp_queue.sv
// Short record queue that decouples the front end from the back end.
// Depends on rpp_pkg for the rec_t record.
module rpp_queue #(
  parameter int DEPTH = rpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  rpp_pkg::rec_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          rd_valid_o,
  output rpp_pkg::rec_t rd_data_o
);
  import rpp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hdl/rpp_back.sv
// Back end: two-stage arithmetic pipeline for swap, grayscale, contrast, blanking and pass-through.
// Depends on rpp_pkg; its last stage is the result register of the block.
module rpp_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [rpp_pkg::GAIN_W-1:0]   gain_i,
  input  logic                                rd_valid_i,
  input  rpp_pkg::rec_t                       rd_data_i,
  output logic                                rd_en_o,
  input  logic                                pop_i,
  output logic                                out_valid_o,
  output logic [rpp_pkg::CH_W-1:0]            red_o,
  output logic [rpp_pkg::CH_W-1:0]            green_o,
  output logic [rpp_pkg::CH_W-1:0]            blue_o,
  output logic                                frame_end_o
);
  import rpp_pkg::*;

  localparam int GRAY_PROD_W = GRAY_SUM_W + 13;

  logic                         v1_q, v2_q, s1_en, s2_en;
  rec_t                         rec1_q;
  logic [GRAY_SUM_W-1:0]        gsum1_q, gsum_d;
  logic signed [CON_PROD_W-1:0] prod1_q [3];
  logic signed [CON_PROD_W-1:0] prod_d [3];
  logic [CH_W-1:0]              chan [3];
  logic [GRAY_PROD_W-1:0]       gprod;
  logic [CH_W-1:0]              gray, con_r, con_g, con_b;
  logic [CH_W-1:0]              red_d, green_d, blue_d;
  logic [CH_W-1:0]              red_q, green_q, blue_q;
  logic                         fe_q;

  // Saturate a biased contrast product to one channel value.
  function automatic logic [CH_W-1:0] con_sat(input logic signed [CON_PROD_W-1:0] p);
    logic signed [CON_SUM_W-1:0] n;
    logic [CON_SUM_W-1:0]        q;
    n = CON_SUM_W'(p) + CON_SUM_W'(CON_BIAS);
    q = CON_SUM_W'(n) >> CON_SHIFT;
    if (n < 0) begin
      return '0;
    end else if (q > CON_SUM_W'(CH_MAX)) begin
      return CH_W'(CH_MAX);
    end
    return q[CH_W-1:0];
  endfunction

  // Stall chain: each stage moves when the one after it has room.
  assign s2_en   = !v2_q || pop_i;
  assign s1_en   = !v1_q || s2_en;
  assign rd_en_o = rd_valid_i && s1_en;

  // Stage one: weighted sum and the three contrast products.
  always_comb begin
    logic signed [CON_DIFF_W-1:0] diff;
    chan[0] = rd_data_i.red;
    chan[1] = rd_data_i.green;
    chan[2] = rd_data_i.blue;
    gsum_d  = GRAY_SUM_W'(chan[0]) * GRAY_SUM_W'(GRAY_WR)
            + GRAY_SUM_W'(chan[1]) * GRAY_SUM_W'(GRAY_WG)
            + GRAY_SUM_W'(chan[2]) * GRAY_SUM_W'(GRAY_WB);
    for (int i = 0; i < 3; i++) begin
      diff      = $signed({1'b0, chan[i], 1'b0}) - CON_DIFF_W'(CH_MAX);
      prod_d[i] = CON_PROD_W'(diff) * CON_PROD_W'(gain_i);
    end
  end

  // Stage two: finish grayscale and contrast, pick the operation.
  always_comb begin
    gprod = GRAY_PROD_W'(gsum1_q) * GRAY_PROD_W'(GRAY_RECIP);
    gray  = gprod[GRAY_SHIFT +: CH_W];
    con_r = con_sat(prod1_q[0]);
    con_g = con_sat(prod1_q[1]);
    con_b = con_sat(prod1_q[2]);
    unique case (rec1_q.op)
      OP_SWAP: begin
        red_d   = rec1_q.green;
        green_d = rec1_q.blue;
        blue_d  = rec1_q.red;
      end
      OP_GRAY: begin
        red_d   = gray;
        green_d = gray;
        blue_d  = gray;
      end
      OP_CONTRAST: begin
        red_d   = con_r;
        green_d = con_g;
        blue_d  = con_b;
      end
      default: begin
        red_d   = rec1_q.red;
        green_d = rec1_q.green;
        blue_d  = rec1_q.blue;
      end
    endcase
    if (rec1_q.blank) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_en) begin
        v1_q <= rd_valid_i;
      end
      if (s2_en) begin
        v2_q <= v1_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      rec1_q  <= rd_data_i;
      gsum1_q <= gsum_d;
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= prod_d[i];
      end
    end
    if (s2_en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      fe_q    <= rec1_q.frame_end;
    end
  end

  assign out_valid_o = v2_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign frame_end_o = fe_q;

endmodule

### hdl/rgb_pixel_point_ops.sv
// Top level of the RGB pixel point-operation block: swap, grayscale, blackout,
// contrast and crop on a raster pixel stream. Depends on rpp_pkg and the rpp_* modules.
//
//   Channel  Direction  Handshake                Payload
//   -------  ---------  -----------------------  ---------------------------------------
//   pixel    in         push / full              red_in_i, green_in_i, blue_in_i
//   result   out        empty / pop              red_out_o, green_out_o, blue_out_o,
//                                                frame_end_o
//   config   in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One pixel per cycle sustained while pop stays high; an accepted pixel is written to a queue
// entry, then passes the product stage and the result register to reach the result ports.
// Reset clears the position counters, empties the queue and the pipeline and
// returns every configuration register to its reset value; no clearing pass is needed.
// With pop low the result register holds, the pipeline fills and the queue of
// QUEUE_DEPTH entries absorbs further pixels before full rises.
// Crop mode drops pixels outside the window in the front end, so they take no slot.
module rgb_pixel_point_ops #(
  parameter int MAX_SIDE    = rpp_pkg::MAX_SIDE_DEF,
  parameter int QUEUE_DEPTH = rpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [rpp_pkg::CH_W-1:0]       red_in_i,
  input  logic [rpp_pkg::CH_W-1:0]       green_in_i,
  input  logic [rpp_pkg::CH_W-1:0]       blue_in_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [rpp_pkg::CH_W-1:0]       red_out_o,
  output logic [rpp_pkg::CH_W-1:0]       green_out_o,
  output logic [rpp_pkg::CH_W-1:0]       blue_out_o,
  output logic                           frame_end_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rpp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rpp_pkg::*;

  cfg_t cfg;
  rec_t wr_rec, rd_rec;
  logic accept, wr_en, rd_en, rd_valid, out_valid, q_full;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  // Configuration registers.
  rpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Position tracking and classification.
  rpp_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .red_i    (red_in_i),
    .green_i  (green_in_i),
    .blue_i   (blue_in_i),
    .wr_en_o  (wr_en),
    .rec_o    (wr_rec)
  );

  // Decoupling queue.
  rpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_data_i  (wr_rec),
    .full_o     (q_full),
    .rd_en_i    (rd_en),
    .rd_valid_o (rd_valid),
    .rd_data_o  (rd_rec)
  );

  // Arithmetic pipeline and result register.
  rpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (cfg.contrast_gain),
    .rd_valid_i  (rd_valid),
    .rd_data_i   (rd_rec),
    .rd_en_o     (rd_en),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o),
    .frame_end_o (frame_end_o)
  );

endmodule
